FILE: src/task_wait_and_semaphore_engine_top_assert.svh
// Assertion macros for the task engine checker
`ifndef TASK_WAIT_AND_SEMAPHORE_ENGINE_TOP_ASSERT_SVH
`define TASK_WAIT_AND_SEMAPHORE_ENGINE_TOP_ASSERT_SVH

// implication check, reset aware
`define TWS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication check, reset aware
`define TWS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: src/tws_pkg.sv
// ----------------------------------------------------------------------------
// tws_pkg
// Shared types and constants of the task wait and semaphore engine.
// ----------------------------------------------------------------------------
`default_nettype none
package tws_pkg;
    localparam int TASK_SLOTS       = 16;
    localparam int SEM_SLOTS        = 32;
    localparam int TICKS_PER_SECOND = 1000;
    localparam int TW = $clog2(TASK_SLOTS);
    localparam int SW = $clog2(SEM_SLOTS);

    localparam logic [2:0] FUNC_TICK   = 3'd0;
    localparam logic [2:0] FUNC_CREATE = 3'd1;
    localparam logic [2:0] FUNC_TWAIT  = 3'd2;
    localparam logic [2:0] FUNC_SWAIT  = 3'd3;
    localparam logic [2:0] FUNC_SIGNAL = 3'd4;

    localparam logic [1:0] KIND_RUN   = 2'd0;
    localparam logic [1:0] KIND_SUM   = 2'd1;
    localparam logic [1:0] KIND_REPLY = 2'd2;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_BAD  = 2'd2;
    localparam logic [1:0] ST_SAT  = 2'd3;

    localparam logic [1:0] EV_NONE    = 2'd0;
    localparam logic [1:0] EV_SIGNAL  = 2'd1;
    localparam logic [1:0] EV_TIMEOUT = 2'd2;

    localparam logic [2:0] COND_ABSENT = 3'd0;
    localparam logic [2:0] COND_READY  = 3'd1;
    localparam logic [2:0] COND_SEM    = 3'd2;
    localparam logic [2:0] COND_TMO    = 3'd4;

    typedef struct packed {
        logic [2:0]  func;
        logic [3:0]  task_req;
        logic [4:0]  sem;
        logic [15:0] amount;
        logic        set_count;
        logic [7:0]  preset_value;
    } t_cmd;

    typedef struct packed {
        logic [1:0]  kind;
        logic [3:0]  task_id;
        logic [1:0]  event_res;
        logic        granted;
        logic [1:0]  status;
        logic [15:0] tick_total;
        logic [15:0] ms_total;
        logic        last;
    } t_res;
endpackage
`default_nettype wire

FILE: src/tws_if.sv
// ----------------------------------------------------------------------------
// tws_cmd_if / tws_res_if
// Valid/ready channels for command and result words.
// ----------------------------------------------------------------------------
`default_nettype none
interface tws_cmd_if;
    logic          valid;
    logic          ready;
    tws_pkg::t_cmd data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface tws_res_if;
    logic          valid;
    logic          ready;
    tws_pkg::t_res data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: src/tws_ms_conv.sv
// ----------------------------------------------------------------------------
// tws_ms_conv
// Converts the tick remainder to milliseconds with one shared multiplier:
// reciprocal estimates for the divisions, each fixed up by one compare.
// ----------------------------------------------------------------------------
`default_nettype none
module tws_ms_conv (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [15:0] i_rem,
    output logic             o_done,
    output logic [15:0]      o_ms,
    output logic [15:0]      o_rem
);
    import tws_pkg::*;
    // ms = floor(rem*1000/TPS); with r = rem*1000 mod TPS the new remainder
    // rem - floor(ms*TPS/1000) equals ceil(r/1000)
    localparam logic [16:0] TPS_K    = 17'(TICKS_PER_SECOND);
    localparam logic [16:0] MUL_MS   = 17'd1000;
    localparam logic [16:0] RCP_TPS  = 17'((64'd1 << 26) / 64'(TICKS_PER_SECOND));
    localparam logic [16:0] RCP_MS   = 17'((64'd1 << 17) / 64'd1000);
    localparam logic [16:0] ROUND_UP = 17'd999;

    localparam logic [2:0] P_IDLE  = 3'd0;
    localparam logic [2:0] P_SCALE = 3'd1;
    localparam logic [2:0] P_QEST  = 3'd2;
    localparam logic [2:0] P_BACK  = 3'd3;
    localparam logic [2:0] P_QFIX  = 3'd4;
    localparam logic [2:0] P_REST  = 3'd5;
    localparam logic [2:0] P_RFIX  = 3'd6;

    logic [2:0]  r_phase;
    logic [25:0] r_num;
    logic [15:0] r_q;
    logic [16:0] r_r;
    logic [15:0] r_rem;
    logic        r_done;
    logic [25:0] w_ma;
    logic [16:0] w_mb;
    logic [42:0] w_prod;

    // one shared multiplier, operands picked by phase
    always_comb begin
        case (r_phase)
            P_QEST: begin
                w_ma = r_num;     w_mb = RCP_TPS;
            end
            P_BACK: begin
                w_ma = 26'(r_q);  w_mb = TPS_K;
            end
            P_REST: begin
                w_ma = 26'(r_r);  w_mb = RCP_MS;
            end
            P_RFIX: begin
                w_ma = 26'(r_rem); w_mb = MUL_MS;
            end
            default: begin
                w_ma = r_num;     w_mb = MUL_MS;
            end
        endcase
    end
    assign w_prod = 43'(w_ma) * 43'(w_mb);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= P_IDLE;
            r_done  <= 1'b0;
            r_num   <= '0;
            r_q     <= '0;
            r_r     <= '0;
            r_rem   <= '0;
        end else begin
            r_done <= (r_phase == P_RFIX);
            case (r_phase)
                P_IDLE: begin
                    if (i_start) begin
                        r_num   <= {10'd0, i_rem};
                        r_phase <= P_SCALE;
                    end
                end
                P_SCALE: begin
                    r_num   <= w_prod[25:0];
                    r_phase <= P_QEST;
                end
                P_QEST: begin
                    // estimate is exact or one low
                    r_q     <= w_prod[41:26];
                    r_phase <= P_BACK;
                end
                P_BACK: begin
                    r_r     <= 17'(r_num - w_prod[25:0]);
                    r_phase <= P_QFIX;
                end
                P_QFIX: begin
                    if (r_r >= TPS_K) begin
                        r_q <= r_q + 16'd1;
                        r_r <= r_r - TPS_K + ROUND_UP;
                    end else begin
                        r_r <= r_r + ROUND_UP;
                    end
                    r_phase <= P_REST;
                end
                P_REST: begin
                    r_rem   <= w_prod[32:17];
                    r_phase <= P_RFIX;
                end
                P_RFIX: begin
                    if (17'(r_r - w_prod[16:0]) >= MUL_MS) r_rem <= r_rem + 16'd1;
                    r_phase <= P_IDLE;
                end
                default: r_phase <= P_IDLE;
            endcase
        end
    end

    assign o_done = r_done;
    assign o_ms   = r_q;
    assign o_rem  = r_rem;
endmodule
`default_nettype wire

FILE: src/tws_core.sv
// ----------------------------------------------------------------------------
// tws_core
// Sequencer over the task table and semaphore pool; tick scans tasks in turn.
// ----------------------------------------------------------------------------
`default_nettype none
module tws_core (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_cfg_we,
    input  wire logic [5:0] i_cfg_wdata,
    tws_cmd_if.sink     cmd,
    tws_res_if.source   res
);
    import tws_pkg::*;
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MS   = 3'd1;
    localparam logic [2:0] S_SCAN = 3'd2;
    localparam logic [2:0] S_OUT  = 3'd3;
    localparam logic [2:0] S_SUM  = 3'd4;

    logic [2:0]  r_state;
    t_cmd        r_cmd;
    logic [5:0]  r_fcs;
    logic [2:0]  r_cond [TASK_SLOTS];
    logic [SW-1:0] r_wsem [TASK_SLOTS];
    logic [15:0] r_timer [TASK_SLOTS];
    logic [1:0]  r_ev [TASK_SLOTS];
    logic [7:0]  r_cnt [SEM_SLOTS];
    logic [TW:0] r_created;
    logic [15:0] r_tsum, r_msum, r_trem;
    logic [TW:0] r_idx;
    logic        r_vld;
    t_res        r_res;
    logic        w_ms_start, w_ms_done;
    logic [15:0] w_ms, w_rem;

    function automatic t_res res_word(logic [1:0] k, logic [3:0] id, logic [1:0] ev,
                                      logic gr, logic [1:0] st, logic [15:0] tt,
                                      logic [15:0] mt, logic lst);
        t_res w;
        w.kind = k; w.task_id = id; w.event_res = ev; w.granted = gr;
        w.status = st; w.tick_total = tt; w.ms_total = mt; w.last = lst;
        return w;
    endfunction

    tws_ms_conv u_ms (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_ms_start), .i_rem(r_trem),
        .o_done(w_ms_done), .o_ms(w_ms), .o_rem(w_rem)
    );

    assign cmd.ready = (r_state == S_IDLE) && !r_vld;
    assign res.valid = r_vld;
    assign res.data  = r_res;
    assign w_ms_start = (r_state == S_MS) && !r_vld && (r_idx == '0);

    logic        w_acc;
    assign w_acc = cmd.valid && cmd.ready;

    // scan element
    logic [TW-1:0] w_i;
    logic [2:0]    w_c;
    logic [1:0]    w_e;
    logic [15:0]   w_t;
    logic [SW-1:0] w_s;
    logic          w_dec;
    assign w_i = r_idx[TW-1:0];
    assign w_s = r_wsem[w_i];
    always_comb begin
        w_c = r_cond[w_i]; w_e = r_ev[w_i]; w_t = r_timer[w_i]; w_dec = 1'b0;
        if (w_c[1] && r_cnt[w_s] != 8'd0) begin
            w_dec = ({1'b0, w_s} >= r_fcs);
            w_e = EV_SIGNAL; w_c = COND_READY;
        end
        if (w_c[2] && w_t != 16'd0) begin
            if (w_t <= r_cmd.amount) begin
                w_t = '0; w_e = EV_TIMEOUT; w_c = COND_READY;
            end else begin
                w_t = w_t - r_cmd.amount;
            end
        end
    end

    logic w_alive;
    logic [TW-1:0] w_ti;
    logic [SW-1:0] w_cs;
    assign w_ti = cmd.data.task_req[TW-1:0];
    assign w_cs = cmd.data.sem[SW-1:0];
    assign w_alive = r_cond[w_ti] != COND_ABSENT;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_vld <= 1'b0;
            r_fcs <= 6'd8;
            r_created <= '0;
            r_tsum <= '0; r_msum <= '0; r_trem <= '0;
            r_idx <= '0;
            for (int k = 0; k < TASK_SLOTS; k++) begin
                r_cond[k] <= COND_ABSENT; r_wsem[k] <= '0;
                r_timer[k] <= '0; r_ev[k] <= EV_NONE;
            end
            for (int k = 0; k < SEM_SLOTS; k++) r_cnt[k] <= '0;
        end else begin
            if (i_cfg_we) r_fcs <= i_cfg_wdata;
            if (r_vld && res.ready) r_vld <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (w_acc) begin
                        r_cmd <= cmd.data;
                        r_vld <= (cmd.data.func != FUNC_TICK);
                        case (cmd.data.func)
                            FUNC_TICK: begin
                                r_tsum <= r_tsum + cmd.data.amount;
                                r_trem <= r_trem + cmd.data.amount;
                                r_idx <= '0;
                                r_state <= S_MS;
                            end
                            FUNC_CREATE: begin
                                if (r_created < (TW+1)'(TASK_SLOTS)) begin
                                    r_cond[r_created[TW-1:0]] <= COND_READY;
                                    r_timer[r_created[TW-1:0]] <= '0;
                                    r_ev[r_created[TW-1:0]] <= EV_NONE;
                                    r_created <= r_created + 1'b1;
                                    r_res <= res_word(KIND_REPLY, 4'(r_created), EV_NONE,
                                                      1'b1, ST_OK, 16'd0, 16'd0, 1'b1);
                                end else begin
                                    r_res <= res_word(KIND_REPLY, 4'd0, EV_NONE,
                                                      1'b0, ST_FULL, 16'd0, 16'd0, 1'b1);
                                end
                            end
                            FUNC_TWAIT: begin
                                r_res <= res_word(KIND_REPLY, cmd.data.task_req,
                                                  w_alive ? r_ev[w_ti] : EV_NONE,
                                                  1'b0, ST_OK, 16'd0, 16'd0, 1'b1);
                                if (w_alive) begin
                                    r_timer[w_ti] <= cmd.data.amount;
                                    r_cond[w_ti] <= COND_TMO;
                                end
                            end
                            FUNC_SWAIT: begin
                                r_res <= res_word(KIND_REPLY, cmd.data.task_req,
                                                  w_alive ? r_ev[w_ti] : EV_NONE,
                                                  w_alive && (r_cnt[w_cs] != 8'd0),
                                                  ST_OK, 16'd0, 16'd0, 1'b1);
                                if (w_alive) begin
                                    if (r_cnt[w_cs] != 8'd0) begin
                                        r_cnt[w_cs] <= r_cnt[w_cs] - 8'd1;
                                        r_cond[w_ti] <= COND_READY;
                                    end else begin
                                        r_wsem[w_ti] <= w_cs;
                                        if (cmd.data.amount != 16'd0) begin
                                            r_timer[w_ti] <= cmd.data.amount;
                                            r_cond[w_ti] <= COND_SEM | COND_TMO;
                                        end else begin
                                            r_cond[w_ti] <= COND_SEM;
                                        end
                                    end
                                end
                            end
                            FUNC_SIGNAL: begin
                                if (cmd.data.set_count) begin
                                    r_cnt[w_cs] <= cmd.data.preset_value;
                                    r_res <= res_word(KIND_REPLY, 4'd0, EV_NONE, 1'b0,
                                                      ST_OK, 16'd0, 16'd0, 1'b1);
                                end else if (r_cnt[w_cs] == 8'hFF) begin
                                    r_res <= res_word(KIND_REPLY, 4'd0, EV_NONE, 1'b0,
                                                      ST_SAT, 16'd0, 16'd0, 1'b1);
                                end else begin
                                    r_cnt[w_cs] <= r_cnt[w_cs] + 8'd1;
                                    r_res <= res_word(KIND_REPLY, 4'd0, EV_NONE, 1'b0,
                                                      ST_OK, 16'd0, 16'd0, 1'b1);
                                end
                            end
                            default: begin
                                r_res <= res_word(KIND_REPLY, 4'd0, EV_NONE, 1'b0,
                                                  ST_OK, 16'd0, 16'd0, 1'b1);
                            end
                        endcase
                    end
                end
                S_MS: begin
                    if (w_ms_done) begin
                        r_trem <= w_rem;
                        r_msum <= r_msum + w_ms;
                        r_idx <= '0;
                        r_state <= S_SCAN;
                    end else begin
                        r_idx <= {{TW{1'b0}}, 1'b1};
                    end
                end
                S_SCAN: begin
                    if (r_idx == (TW+1)'(TASK_SLOTS) || r_cond[w_i] == COND_ABSENT) begin
                        r_state <= S_SUM;
                    end else begin
                        r_cond[w_i] <= w_c; r_ev[w_i] <= w_e; r_timer[w_i] <= w_t;
                        if (w_dec) r_cnt[w_s] <= r_cnt[w_s] - 8'd1;
                        r_idx <= r_idx + 1'b1;
                        if (w_c == COND_READY) begin
                            r_res <= res_word(KIND_RUN, 4'(w_i), w_e, 1'b0, ST_OK,
                                              16'd0, 16'd0, 1'b0);
                            r_vld <= 1'b1;
                            r_state <= S_OUT;
                        end
                    end
                end
                S_OUT: begin
                    if (!r_vld || res.ready) r_state <= S_SCAN;
                end
                S_SUM: begin
                    if (!r_vld || res.ready) begin
                        r_res <= res_word(KIND_SUM, 4'd0, EV_NONE, 1'b0, ST_OK,
                                          r_tsum, r_msum, 1'b1);
                        r_vld <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

FILE: src/task_wait_and_semaphore_engine_top.sv
// Create, wait and signal reply in the cycle after the command word is taken.
// Tick: the ms conversion runs on the shared multiplier, then the scan visits each
// created task in turn, pausing for each run word, then ends the scan and sends the
// summary word; stalls on the result channel hold the scan.
// One command at a time; the next is taken once the last word has left.
// Synchronous active-low reset empties the task table and clears all counts.
// ----------------------------------------------------------------------------
// task_wait_and_semaphore_engine_top
// Top level of the cooperative task kernel with semaphores.
// ----------------------------------------------------------------------------
`default_nettype none
module task_wait_and_semaphore_engine_top (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_we,
    input  wire logic [5:0] i_cfg_wdata,
    tws_cmd_if.sink         i_cmd,
    tws_res_if.source       o_res
);
    import tws_pkg::*;
    tws_core u_core (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata), .cmd(i_cmd), .res(o_res)
    );
endmodule
`default_nettype wire

FILE: src/tws_checker.sv
// ----------------------------------------------------------------------------
// tws_checker
// Port-level checks on the engine's command and result channels.
// ----------------------------------------------------------------------------
`default_nettype none
`include "task_wait_and_semaphore_engine_top_assert.svh"
module tws_checker (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic cmd_valid,
    input wire logic cmd_ready,
    input wire logic res_valid,
    input wire logic res_ready,
    input wire logic [1:0] res_kind,
    input wire logic res_last
);
    import tws_pkg::*;
    `TWS_ASSERT_IMP(a_no_take_while_out, i_clk, i_rst_n, res_valid, !cmd_ready)
    `TWS_ASSERT_IMP(a_sum_last, i_clk, i_rst_n, res_valid && res_kind == KIND_SUM, res_last)
    `TWS_ASSERT_IMP(a_run_notlast, i_clk, i_rst_n, res_valid && res_kind == KIND_RUN, !res_last)
    `TWS_ASSERT_NEXT(a_hold, i_clk, i_rst_n, res_valid && !res_ready, res_valid)
    // a taken command word keeps the input closed in the cycle after the take
    `TWS_ASSERT_NEXT(a_busy_after_take, i_clk, i_rst_n, cmd_valid && cmd_ready, !cmd_ready)
endmodule

bind task_wait_and_semaphore_engine_top tws_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .cmd_valid(i_cmd.valid), .cmd_ready(i_cmd.ready),
    .res_valid(o_res.valid), .res_ready(o_res.ready),
    .res_kind(o_res.data.kind), .res_last(o_res.data.last)
);
`default_nettype wire

FILE: bench/tb_task_wait_and_semaphore_engine_top.sv
// ----------------------------------------------------------------------------
// tb_task_wait_and_semaphore_engine_top
// Self-checking bench: commands are driven over the valid/ready channel, a
// behavioral model of the task table and semaphore pool predicts every
// result word, and a checker compares each received word field by field.
// ----------------------------------------------------------------------------
`default_nettype none
module tb_task_wait_and_semaphore_engine_top;
    import tws_pkg::*;

    localparam logic [2:0] FUNC_TOP = 3'd7;
    localparam int CYCLE_LIMIT = 600000;
    localparam int HOLD_CYCLES = 400;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_cfg_we;
    logic [5:0] i_cfg_wdata;

    tws_cmd_if cmd_ch ();
    tws_res_if res_ch ();

    task_wait_and_semaphore_engine_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd       (cmd_ch.sink),
        .o_res       (res_ch.source)
    );

    // kernel model state
    logic [2:0]  task_cond [TASK_SLOTS];
    logic [4:0]  task_sem  [TASK_SLOTS];
    logic [15:0] task_tmr  [TASK_SLOTS];
    logic [1:0]  task_ev   [TASK_SLOTS];
    logic [7:0]  sem_cnt   [SEM_SLOTS];
    int          num_created;
    logic [15:0] tick_acc;
    logic [15:0] ms_acc;
    logic [15:0] tick_rem;
    logic [5:0]  counted_floor;

    t_res expected_words [$];
    int   err_cnt;
    int   cycle_cnt;
    bit   idle_on;
    bit   pressure_go;
    bit   pressure_seen;
    int   hold_left;
    int   stall_left;

    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    function automatic t_res make_res(logic [1:0] k, logic [3:0] id, logic [1:0] ev,
                                      logic gr, logic [1:0] st, logic [15:0] tt,
                                      logic [15:0] mt, logic lst);
        t_res r;
        r.kind = k; r.task_id = id; r.event_res = ev; r.granted = gr;
        r.status = st; r.tick_total = tt; r.ms_total = mt; r.last = lst;
        return r;
    endfunction

    function automatic t_cmd make_cmd(logic [2:0] f, logic [3:0] t, logic [4:0] s,
                                      logic [15:0] amt, logic sc, logic [7:0] pv);
        t_cmd c;
        c.func = f; c.task_req = t; c.sem = s; c.amount = amt;
        c.set_count = sc; c.preset_value = pv;
        return c;
    endfunction

    task automatic kernel_reset();
        for (int i = 0; i < TASK_SLOTS; i++) begin
            task_cond[i] = COND_ABSENT; task_sem[i] = '0;
            task_tmr[i] = '0; task_ev[i] = EV_NONE;
        end
        for (int i = 0; i < SEM_SLOTS; i++) sem_cnt[i] = '0;
        num_created = 0; tick_acc = '0; ms_acc = '0; tick_rem = '0;
        counted_floor = 6'd8;
    endtask

    task automatic predict_kernel(t_cmd c);
        logic        alive;
        logic [31:0] ms;
        int          t;
        int          s;
        t = c.task_req;
        s = c.sem;
        alive = (t < TASK_SLOTS) && (task_cond[t] != COND_ABSENT);
        case (c.func)
            FUNC_TICK: begin
                tick_acc = tick_acc + c.amount;
                tick_rem = tick_rem + c.amount;
                ms = (32'(tick_rem) * 1000) / TICKS_PER_SECOND;
                tick_rem = tick_rem - 16'((ms * TICKS_PER_SECOND) / 1000);
                ms_acc = ms_acc + 16'(ms);
                for (int i = 0; i < TASK_SLOTS && task_cond[i] != COND_ABSENT; i++) begin
                    if ((task_cond[i] & COND_SEM) != 0 && task_sem[i] < SEM_SLOTS
                        && sem_cnt[task_sem[i]] != 0) begin
                        if (task_sem[i] >= counted_floor)
                            sem_cnt[task_sem[i]]--;
                        task_ev[i] = EV_SIGNAL;
                        task_cond[i] = COND_READY;
                    end
                    if ((task_cond[i] & COND_TMO) != 0 && task_tmr[i] != 0) begin
                        if (task_tmr[i] <= c.amount) begin
                            task_tmr[i] = '0;
                            task_ev[i] = EV_TIMEOUT;
                            task_cond[i] = COND_READY;
                        end else begin
                            task_tmr[i] = task_tmr[i] - c.amount;
                        end
                    end
                    if (task_cond[i] == COND_READY)
                        expected_words.push_back(make_res(KIND_RUN, 4'(i), task_ev[i],
                                                          0, ST_OK, 0, 0, 0));
                end
                expected_words.push_back(make_res(KIND_SUM, 0, EV_NONE, 0, ST_OK,
                                                  tick_acc, ms_acc, 1));
            end
            FUNC_CREATE: begin
                if (num_created < TASK_SLOTS) begin
                    task_cond[num_created] = COND_READY;
                    task_tmr[num_created] = '0;
                    task_ev[num_created] = EV_NONE;
                    expected_words.push_back(make_res(KIND_REPLY, 4'(num_created), EV_NONE,
                                                      1, ST_OK, 0, 0, 1));
                    num_created++;
                end else begin
                    expected_words.push_back(make_res(KIND_REPLY, 0, EV_NONE, 0, ST_FULL,
                                                      0, 0, 1));
                end
            end
            FUNC_TWAIT: begin
                if (alive) begin
                    task_tmr[t] = c.amount;
                    task_cond[t] = COND_TMO;
                    expected_words.push_back(make_res(KIND_REPLY, c.task_req, task_ev[t],
                                                      0, ST_OK, 0, 0, 1));
                end else begin
                    expected_words.push_back(make_res(KIND_REPLY, c.task_req, EV_NONE,
                                                      0, ST_OK, 0, 0, 1));
                end
            end
            FUNC_SWAIT: begin
                if (s >= SEM_SLOTS) begin
                    expected_words.push_back(make_res(KIND_REPLY, c.task_req,
                                                      alive ? task_ev[t] : EV_NONE,
                                                      0, ST_BAD, 0, 0, 1));
                end else if (!alive) begin
                    expected_words.push_back(make_res(KIND_REPLY, c.task_req, EV_NONE,
                                                      0, ST_OK, 0, 0, 1));
                end else if (sem_cnt[s] != 0) begin
                    sem_cnt[s]--;
                    task_cond[t] = COND_READY;
                    expected_words.push_back(make_res(KIND_REPLY, c.task_req, task_ev[t],
                                                      1, ST_OK, 0, 0, 1));
                end else begin
                    task_sem[t] = c.sem;
                    task_cond[t] = COND_SEM;
                    if (c.amount != 0) begin
                        task_tmr[t] = c.amount;
                        task_cond[t] = COND_SEM | COND_TMO;
                    end
                    expected_words.push_back(make_res(KIND_REPLY, c.task_req, task_ev[t],
                                                      0, ST_OK, 0, 0, 1));
                end
            end
            FUNC_SIGNAL: begin
                if (s >= SEM_SLOTS) begin
                    expected_words.push_back(make_res(KIND_REPLY, 0, EV_NONE, 0, ST_BAD,
                                                      0, 0, 1));
                end else if (c.set_count) begin
                    sem_cnt[s] = c.preset_value;
                    expected_words.push_back(make_res(KIND_REPLY, 0, EV_NONE, 0, ST_OK,
                                                      0, 0, 1));
                end else if (sem_cnt[s] == 8'd255) begin
                    expected_words.push_back(make_res(KIND_REPLY, 0, EV_NONE, 0, ST_SAT,
                                                      0, 0, 1));
                end else begin
                    sem_cnt[s]++;
                    expected_words.push_back(make_res(KIND_REPLY, 0, EV_NONE, 0, ST_OK,
                                                      0, 0, 1));
                end
            end
            default: expected_words.push_back(make_res(KIND_REPLY, 0, EV_NONE, 0, ST_OK,
                                                       0, 0, 1));
        endcase
    endtask

    task automatic report(string msg);
        $display("MISMATCH @%0d: %s", cycle_cnt, msg);
        err_cnt++;
    endtask

    // drive one command word; valid stays high unless an idle gap follows
    task automatic send_cmd(t_cmd c);
        cmd_ch.valid <= 1'b1;
        cmd_ch.data  <= c;
        do @(posedge i_clk); while (!cmd_ch.ready);
        predict_kernel(c);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            cmd_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        cmd_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (expected_words.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic write_floor(logic [5:0] v);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        counted_floor = v;
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_res got;
        t_res want;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            got = res_ch.data;
            if (expected_words.size() == 0) begin
                report($sformatf("unexpected word %h", got));
            end else begin
                want = expected_words.pop_front();
                if (got.kind != want.kind)
                    report($sformatf("kind %0d exp %0d", got.kind, want.kind));
                if (got.task_id != want.task_id)
                    report($sformatf("task_id %0d exp %0d", got.task_id, want.task_id));
                if (got.event_res != want.event_res)
                    report($sformatf("event_res %0d exp %0d", got.event_res, want.event_res));
                if (got.granted != want.granted)
                    report($sformatf("granted %0d exp %0d", got.granted, want.granted));
                if (got.status != want.status)
                    report($sformatf("status %0d exp %0d", got.status, want.status));
                if (got.tick_total != want.tick_total)
                    report($sformatf("tick_total %0d exp %0d", got.tick_total,
                                     want.tick_total));
                if (got.ms_total != want.ms_total)
                    report($sformatf("ms_total %0d exp %0d", got.ms_total, want.ms_total));
                if (got.last != want.last)
                    report($sformatf("last %0d exp %0d", got.last, want.last));
            end
        end
    end

    // receiver: random stalls plus one long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
            hold_left    <= 0;
            stall_left   <= 0;
        end else if (hold_left > 0) begin
            res_ch.ready <= 1'b0;
            hold_left    <= hold_left - 1;
        end else if (pressure_go && !pressure_seen) begin
            pressure_seen <= 1'b1;
            hold_left     <= HOLD_CYCLES;
            res_ch.ready  <= 1'b0;
        end else if (idle_on && stall_left > 0) begin
            res_ch.ready <= 1'b0;
            stall_left   <= stall_left - 1;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
            res_ch.ready <= 1'b0;
            stall_left   <= $urandom_range(0, 13);
        end else begin
            res_ch.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic t_cmd rand_cmd();
        int          pick;
        logic [15:0] amt;
        pick = $urandom_range(0, 99);
        amt  = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 40));
        if (pick < 25)
            return make_cmd(FUNC_TICK, 0, 0, amt, 0, 0);
        else if (pick < 40)
            return make_cmd(FUNC_TWAIT, 4'($urandom), 0, amt, 0, 0);
        else if (pick < 65)
            return make_cmd(FUNC_SWAIT, 4'($urandom), 5'($urandom_range(0, 15)),
                            ($urandom_range(0, 2) == 0) ? 16'd0 : amt, 0, 0);
        else if (pick < 90)
            return make_cmd(FUNC_SIGNAL, 4'($urandom),
                            ($urandom_range(0, 7) == 0) ? 5'($urandom)
                                                        : 5'($urandom_range(0, 15)),
                            16'($urandom), ($urandom_range(0, 3) == 0), 8'($urandom));
        else if (pick < 94)
            return make_cmd(FUNC_CREATE, 4'($urandom), 5'($urandom), 16'($urandom), 0, 0);
        else
            return make_cmd(3'($urandom_range(FUNC_SIGNAL + 1, FUNC_TOP)), 4'($urandom),
                            5'($urandom), 16'($urandom), 1'($urandom), 8'($urandom));
    endfunction

    task automatic test_directed();
        send_cmd(make_cmd(FUNC_TWAIT, 4'd15, 0, 16'd10, 0, 0));          // absent task
        send_cmd(make_cmd(FUNC_SWAIT, 4'd3, 5'd31, 16'd10, 0, 0));        // absent task
        for (int i = 0; i <= TASK_SLOTS; i++)                             // last one: full
            send_cmd(make_cmd(FUNC_CREATE, 0, 0, 0, 0, 0));
        send_cmd(make_cmd(FUNC_TICK, 0, 0, 16'hFFFF, 0, 0));
        send_cmd(make_cmd(FUNC_SIGNAL, 0, 5'd0, 0, 1, 8'd255));
        send_cmd(make_cmd(FUNC_SIGNAL, 0, 5'd0, 0, 0, 0));               // saturates
        send_cmd(make_cmd(FUNC_SWAIT, 4'd0, 5'd0, 0, 0, 0));             // immediate
        send_cmd(make_cmd(FUNC_SWAIT, 4'd1, 5'd9, 16'd0, 0, 0));
        send_cmd(make_cmd(FUNC_TWAIT, 4'd2, 0, 16'd5, 0, 0));
        send_cmd(make_cmd(FUNC_SWAIT, 4'd3, 5'd31, 16'd3, 0, 0));
        send_cmd(make_cmd(FUNC_TWAIT, 4'd4, 0, 16'd0, 0, 0));            // never expires
        send_cmd(make_cmd(FUNC_SIGNAL, 0, 5'd9, 0, 0, 0));
        send_cmd(make_cmd(FUNC_TICK, 0, 0, 16'd0, 0, 0));
        send_cmd(make_cmd(FUNC_TICK, 0, 0, 16'd4, 0, 0));
        for (logic [3:0] f = FUNC_SIGNAL + 1; f <= FUNC_TOP; f++)
            send_cmd(make_cmd(f[2:0], 4'hF, 5'h1F, 16'hFFFF, 1, 8'hFF));
    endtask

    task automatic test_random(int count, bit with_pressure);
        for (int i = 0; i < count; i++) begin
            if (with_pressure && i == count / 2) pressure_go = 1'b1;
            send_cmd(rand_cmd());
        end
    endtask

    task automatic test_floor_settings();
        write_floor(6'd0);
        test_random(70, 1'b0);
        write_floor(6'd32);
        test_random(70, 1'b1);
        write_floor(6'd31);
        test_random(70, 1'b0);
        write_floor(6'($urandom_range(1, 30)));
        idle_on = 1'b0;
        test_random(70, 1'b0);
    endtask

    initial begin
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_wdata   <= '0;
        cmd_ch.valid  <= 1'b0;
        cmd_ch.data   <= '0;
        err_cnt       = 0;
        cycle_cnt     = 0;
        idle_on       = 1'b1;
        pressure_go   = 1'b0;
        pressure_seen = 1'b0;
        kernel_reset();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_floor_settings();
        drain();
        if (err_cnt == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
`default_nettype wire
